@@ src/plnp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the polyline nearest-point store.
// Used by the controller, the datapath, the top level and the checker.
package plnp_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int COORD_W        = 16;
   localparam int SQ_W           = 33;
   localparam int DIST_W         = 34;
   localparam int POINT_W        = 2 * COORD_W;

   typedef enum logic [1:0] {
      FN_START  = 2'd0,
      FN_INSERT = 2'd1,
      FN_MOVE   = 2'd2,
      FN_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_REQ   = 2'd0,
      WR_RD    = 2'd1,
      WR_MOVED = 2'd2
   } wr_src_type;

   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      logic       scan_rd;
      logic       ofs_load;
      logic       wr_en;
      wr_src_type wr_src;
      logic       cnt_set1;
      logic       cnt_incr;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_coords;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic best_zero;
      logic cnt_zero;
      logic cnt_full;
      logic rsp_hold;
   } dp_stat_type;

endpackage

@@ src/plnp_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plnp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/plnp_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the polyline store: scan, shift, move and response steps.
// Depends on plnp_pkg; drives the datapath through ctrl_cmd_type.
module plnp_ctrl
   import plnp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  dp_stat_type                     stat,
   input  logic [$clog2(MAX_POINTS+1)-1:0] count,
   input  logic [$clog2(MAX_POINTS)-1:0]   best_idx,
   output ctrl_cmd_type                    cmd,
   output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
   output logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
   output logic [$clog2(MAX_POINTS)-1:0]   rsp_index
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_SHIFT,
      S_SHIFT_WB,
      S_PUT,
      S_MOVE_BASE,
      S_MOVE_OFS,
      S_MOVE,
      S_MOVE_WB,
      S_RESP
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          wb_pend_ff, wb_pend_in;
   logic [AW-1:0] wb_addr_ff, wb_addr_in;
   func_type      func_ff, func_in;
   logic [AW-1:0] pos_ff, pos_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_index_ff, rsp_index_in;
   logic          rsp_coords_ff, rsp_coords_in;

   logic [CW-1:0] last;
   logic          ptr_last;

   assign last     = count - CW'(1);
   assign ptr_last = (CW'(ptr_ff) == last);

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      wb_pend_in    = wb_pend_ff;
      wb_addr_in    = wb_addr_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_coords_in = rsp_coords_ff;
      cmd           = '0;
      cmd.wr_src    = WR_REQ;
      cmd.rsp_status = rsp_status_ff;
      cmd.rsp_coords = rsp_coords_ff;
      rd_addr       = ptr_ff;
      wr_addr       = wb_addr_ff;
      req_stall     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.req_load  = 1'b1;
               func_in       = func_type'(req_func);
               ptr_in        = '0;
               wb_pend_in    = 1'b0;
               rsp_coords_in = 1'b0;
               rsp_index_in  = '0;
               rsp_status_in = ST_OK;
               if (func_type'(req_func) == FN_START) begin
                  pos_in   = '0;
                  state_in = S_PUT;
               end else if (stat.cnt_zero) begin
                  rsp_status_in = ST_EMPTY;
                  state_in      = S_RESP;
               end else if (func_type'(req_func) == FN_MOVE) begin
                  state_in = S_MOVE_BASE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.scan_rd = 1'b1;
            if (ptr_last) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            if (!stat.scan_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_index_in = best_idx;
            if (func_ff == FN_QUERY) begin
               rsp_status_in = ST_OK;
               rsp_coords_in = 1'b1;
               state_in      = S_RESP;
            end else if (stat.best_zero) begin
               rsp_status_in = ST_DUP;
               state_in      = S_RESP;
            end else if (stat.cnt_full) begin
               rsp_status_in = ST_FULL;
               state_in      = S_RESP;
            end else if (CW'(best_idx) == last) begin
               pos_in   = AW'(count);
               state_in = S_PUT;
            end else begin
               pos_in     = best_idx;
               ptr_in     = AW'(last);
               wb_pend_in = 1'b0;
               state_in   = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = wb_pend_ff;
            cmd.wr_src = WR_RD;
            wb_pend_in = 1'b1;
            wb_addr_in = ptr_ff + AW'(1);
            if (ptr_ff == pos_ff) begin
               state_in = S_SHIFT_WB;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         S_SHIFT_WB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_RD;
            wb_pend_in = 1'b0;
            state_in   = S_PUT;
         end
         S_PUT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_src    = WR_REQ;
            wr_addr       = pos_ff;
            cmd.cnt_set1  = (func_ff == FN_START);
            cmd.cnt_incr  = (func_ff != FN_START);
            rsp_status_in = ST_OK;
            rsp_index_in  = pos_ff;
            state_in      = S_RESP;
         end
         S_MOVE_BASE: begin
            cmd.rd_en = 1'b1;
            rd_addr   = '0;
            state_in  = S_MOVE_OFS;
         end
         S_MOVE_OFS: begin
            cmd.ofs_load = 1'b1;
            ptr_in       = '0;
            wb_pend_in   = 1'b0;
            state_in     = S_MOVE;
         end
         S_MOVE: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = wb_pend_ff;
            cmd.wr_src = WR_MOVED;
            wb_pend_in = 1'b1;
            wb_addr_in = ptr_ff;
            if (ptr_last) begin
               state_in = S_MOVE_WB;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_MOVE_WB: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_src    = WR_MOVED;
            wb_pend_in    = 1'b0;
            rsp_status_in = ST_OK;
            rsp_index_in  = '0;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_hold) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         wb_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wb_pend_ff <= wb_pend_in;
      end
      ptr_ff        <= ptr_in;
      wb_addr_ff    <= wb_addr_in;
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_coords_ff <= rsp_coords_in;
   end

endmodule

@@ src/plnp_dp.sv @@
`timescale 1ns / 1ps
// Datapath: point RAM, distance pipeline, best tracker, move offset,
// point count and response register. Depends on plnp_pkg and plnp_ram.
module plnp_dp
   import plnp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [COORD_W-1:0]       req_x_coord,
   input  logic signed [COORD_W-1:0]       req_y_coord,
   input  ctrl_cmd_type                    cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
   input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
   input  logic [$clog2(MAX_POINTS)-1:0]   rsp_index,
   output dp_stat_type                     stat,
   output logic [$clog2(MAX_POINTS+1)-1:0] count,
   output logic [$clog2(MAX_POINTS)-1:0]   best_idx,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_found_index,
   output logic signed [COORD_W-1:0]       rsp_found_x,
   output logic signed [COORD_W-1:0]       rsp_found_y,
   output logic [8:0]                      rsp_point_count
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic [POINT_W-1:0]        rd_data, wr_data;
   logic signed [COORD_W-1:0] rd_x, rd_y;

   logic                      s1_vld_ff;
   logic [AW-1:0]             s1_idx_ff;
   logic                      s2_vld_ff;
   logic [AW-1:0]             s2_idx_ff;
   logic signed [COORD_W-1:0] s2_x_ff, s2_y_ff;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
   logic [DIST_W-1:0]         dist_sum;

   logic [DIST_W-1:0]         best_d_ff;
   logic [AW-1:0]             best_idx_ff;
   logic signed [COORD_W-1:0] best_x_ff, best_y_ff;
   logic signed [COORD_W:0]   ofs_x_ff, ofs_y_ff;
   logic signed [COORD_W+1:0] mv_x, mv_y;

   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff;
   logic [7:0]                rsp_index_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [8:0]                rsp_count_ff;
   logic [AW+7:0]             idx_ext;
   logic [CW+8:0]             cnt_ext;

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W+1:0] hi, lo;
      hi = (COORD_W+2)'(32767);
      lo = -(COORD_W+2)'(32768);
      if (v > hi) begin
         return COORD_W'(hi);
      end else if (v < lo) begin
         return COORD_W'(lo);
      end
      return COORD_W'(v);
   endfunction

   assign rd_x = rd_data[POINT_W-1:COORD_W];
   assign rd_y = rd_data[COORD_W-1:0];

   always_comb begin
      mv_x = (COORD_W+2)'(rd_x) + (COORD_W+2)'(ofs_x_ff);
      mv_y = (COORD_W+2)'(rd_y) + (COORD_W+2)'(ofs_y_ff);
      case (cmd.wr_src)
         WR_REQ:   wr_data = {px_ff, py_ff};
         WR_RD:    wr_data = rd_data;
         WR_MOVED: wr_data = {sat16(mv_x), sat16(mv_y)};
         default:  wr_data = rd_data;
      endcase
   end

   plnp_ram #(
      .WIDTH(POINT_W),
      .DEPTH(MAX_POINTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // distance pipeline: RAM read, squares, sum and compare
   always_comb begin
      dx       = (COORD_W+1)'(rd_x) - (COORD_W+1)'(px_ff);
      dy       = (COORD_W+1)'(rd_y) - (COORD_W+1)'(py_ff);
      dx_sq    = dx * dx;
      dy_sq    = dy * dy;
      sqx_in   = dx_sq[SQ_W-1:0];
      sqy_in   = dy_sq[SQ_W-1:0];
      dist_sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_set1) begin
         count_in = CW'(1);
      end else if (cmd.cnt_incr) begin
         count_in = count_ff + CW'(1);
      end
   end

   assign idx_ext = {8'b0, rsp_index};
   assign cnt_ext = {9'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         s1_vld_ff <= cmd.scan_rd;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.req_load) begin
         px_ff <= req_x_coord;
         py_ff <= req_y_coord;
      end
      s1_idx_ff <= rd_addr;
      s2_idx_ff <= s1_idx_ff;
      s2_x_ff   <= rd_x;
      s2_y_ff   <= rd_y;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;

      if (s2_vld_ff && ((s2_idx_ff == '0) || (dist_sum < best_d_ff))) begin
         best_d_ff   <= dist_sum;
         best_idx_ff <= s2_idx_ff;
         best_x_ff   <= s2_x_ff;
         best_y_ff   <= s2_y_ff;
      end

      if (cmd.ofs_load) begin
         ofs_x_ff <= (COORD_W+1)'(px_ff) - (COORD_W+1)'(rd_x);
         ofs_y_ff <= (COORD_W+1)'(py_ff) - (COORD_W+1)'(rd_y);
      end

      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_index_ff  <= idx_ext[7:0];
         rsp_x_ff      <= cmd.rsp_coords ? best_x_ff : '0;
         rsp_y_ff      <= cmd.rsp_coords ? best_y_ff : '0;
         rsp_count_ff  <= cnt_ext[8:0];
      end
   end

   assign count          = count_ff;
   assign best_idx       = best_idx_ff;
   assign stat.scan_busy = s1_vld_ff | s2_vld_ff;
   assign stat.best_zero = (best_d_ff == '0);
   assign stat.cnt_zero  = (count_ff == '0);
   assign stat.cnt_full  = (count_ff == CW'(MAX_POINTS));
   assign stat.rsp_hold  = rsp_valid_ff & rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_found_x     = rsp_x_ff;
   assign rsp_found_y     = rsp_y_ff;
   assign rsp_point_count = rsp_count_ff;

endmodule

@@ src/polyline_nearest_point_store.sv @@
`timescale 1ns / 1ps
// Polyline point store with nearest-point search; one request at a time.
// An insert is rejected, appended, or placed before the nearest point,
// which shifts up with the points after it. Throughput is set by the scan
// over the point RAM, one read a cycle. Synchronous reset empties the list.
module polyline_nearest_point_store
   import plnp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_func,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [7:0]                rsp_found_index,
   output logic signed [COORD_W-1:0] rsp_found_x,
   output logic signed [COORD_W-1:0] rsp_found_y,
   output logic [8:0]                rsp_point_count
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   ctrl_cmd_type  cmd;
   dp_stat_type   stat;
   logic [CW-1:0] count;
   logic [AW-1:0] best_idx;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rsp_index;

   plnp_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func (req_func),
      .stat     (stat),
      .count    (count),
      .best_idx (best_idx),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .rsp_index(rsp_index)
   );

   plnp_dp #(
      .MAX_POINTS(MAX_POINTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .rsp_index      (rsp_index),
      .stat           (stat),
      .count          (count),
      .best_idx       (best_idx),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_found_x    (rsp_found_x),
      .rsp_found_y    (rsp_found_y),
      .rsp_point_count(rsp_point_count)
   );

endmodule

@@ src/plnp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the polyline store, bound to the top level.
// Depends on plnp_pkg and polyline_nearest_point_store.
module plnp_checker
   import plnp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic [7:0]                rsp_found_index,
   input logic signed [COORD_W-1:0] rsp_found_x,
   input logic signed [COORD_W-1:0] rsp_found_y,
   input logic [8:0]                rsp_point_count
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_index) && $stable(rsp_point_count))
      else $error("stalled response beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_point_count == 9'd0)
         && (rsp_found_index == 8'd0))
      else $error("empty-list response carries data");

   a_coords_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_found_x == '0) && (rsp_found_y == '0))
      else $error("coordinates on a non-ok response");

endmodule

bind polyline_nearest_point_store plnp_checker u_plnp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_found_index(rsp_found_index),
   .rsp_found_x    (rsp_found_x),
   .rsp_found_y    (rsp_found_y),
   .rsp_point_count(rsp_point_count)
);

@@ bench/tb_polyline_nearest_point_store.sv @@
`timescale 1ns / 1ps
// Self-checking bench for polyline_nearest_point_store: directed and random requests,
// with a mirrored point list that predicts every reply. Depends on plnp_pkg and the RTL.
module tb_polyline_nearest_point_store;
   import plnp_pkg::*;

   localparam int MAX_PTS        = MAX_POINTS_DEF;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      status_type         status;
      logic [7:0]         index;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [8:0]         count;
   } reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_func = '0;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic [7:0]                rsp_found_index;
   logic signed [COORD_W-1:0] rsp_found_x;
   logic signed [COORD_W-1:0] rsp_found_y;
   logic [8:0]                rsp_point_count;

   logic signed [15:0] pts_x [MAX_PTS];
   logic signed [15:0] pts_y [MAX_PTS];
   int                 point_total = 0;
   reply_type          pending_replies [$];
   int                 fail_count = 0;
   logic               req_gaps_on = 1'b1;
   logic               rsp_gaps_on = 1'b1;
   int unsigned        quiet_cycles = 0;

   polyline_nearest_point_store #(
      .MAX_POINTS(MAX_PTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_found_x    (rsp_found_x),
      .rsp_found_y    (rsp_found_y),
      .rsp_point_count(rsp_point_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [15:0] sat_coord(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic int nearest_point(input logic signed [15:0] px, py, output longint best);
      longint dx, dy, d;
      int     n;
      n = 0;
      best = -1;
      for (int i = 0; i < point_total; i++) begin
         dx = longint'(pts_x[i]) - longint'(px);
         dy = longint'(pts_y[i]) - longint'(py);
         d = dx * dx + dy * dy;
         if (i == 0 || d < best) begin
            best = d;
            n = i;
         end
      end
      return n;
   endfunction

   function automatic reply_type run_store_request(func_type f, logic signed [15:0] px, py);
      reply_type r;
      longint    best, rx, ry;
      int        n, pos;
      r = '0;
      r.status = ST_OK;
      if (f == FN_START) begin
         pts_x[0] = px;
         pts_y[0] = py;
         point_total = 1;
      end else if (point_total == 0) begin
         r.status = ST_EMPTY;
      end else if (f == FN_INSERT) begin
         n = nearest_point(px, py, best);
         r.index = 8'(n);
         if (best == 0) begin
            r.status = ST_DUP;
         end else if (point_total >= MAX_PTS) begin
            r.status = ST_FULL;
         end else begin
            pos = (n == point_total - 1) ? point_total : n;
            for (int i = point_total; i > pos; i--) begin
               pts_x[i] = pts_x[i-1];
               pts_y[i] = pts_y[i-1];
            end
            pts_x[pos] = px;
            pts_y[pos] = py;
            point_total++;
            r.index = 8'(pos);
         end
      end else if (f == FN_MOVE) begin
         rx = longint'(px) - longint'(pts_x[0]);
         ry = longint'(py) - longint'(pts_y[0]);
         for (int i = 0; i < point_total; i++) begin
            pts_x[i] = sat_coord(longint'(pts_x[i]) + rx);
            pts_y[i] = sat_coord(longint'(pts_y[i]) + ry);
         end
      end else begin
         n = nearest_point(px, py, best);
         r.index = 8'(n);
         r.x = pts_x[n];
         r.y = pts_y[n];
      end
      r.count = 9'(point_total);
      return r;
   endfunction

   function automatic logic signed [15:0] extreme_coord();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh8001;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sh7FFE;
         default: return 16'sh7FFF;
      endcase
   endfunction

   task automatic pick_point(output logic signed [15:0] px, py);
      int mode, k, dx, dy;
      mode = $urandom_range(99);
      if (mode < 40 && point_total > 0) begin
         k = $urandom_range(point_total - 1);
         dx = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(6)) - 3;
         dy = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(6)) - 3;
         px = sat_coord(longint'(pts_x[k]) + dx);
         py = sat_coord(longint'(pts_y[k]) + dy);
      end else if (mode < 70) begin
         px = 16'(int'($urandom_range(127)) - 64);
         py = 16'(int'($urandom_range(127)) - 64);
      end else if (mode < 90) begin
         px = 16'($urandom);
         py = 16'($urandom);
      end else begin
         px = extreme_coord();
         py = extreme_coord();
      end
   endtask

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", msg);
   endtask

   task automatic send_request(func_type f, logic signed [15:0] px, py);
      while (req_gaps_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_x_coord <= px;
      req_y_coord <= py;
      do @(posedge clock); while (req_stall);
      pending_replies.insert(pending_replies.size(), run_store_request(f, px, py));
   endtask

   task automatic wait_replies_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // Reply checker and result-side backpressure
   always @(posedge clock) begin
      reply_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = status_type'(rsp_status);
         got.index  = rsp_found_index;
         got.x      = rsp_found_x;
         got.y      = rsp_found_y;
         got.count  = rsp_point_count;
         if (pending_replies.size() == 0) begin
            report_failure($sformatf("unexpected reply beat st=%0d idx=%0d n=%0d",
                                     got.status, got.index, got.count));
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.x !== want.x || got.y !== want.y || got.count !== want.count)
               report_failure($sformatf(
                  "want st=%0d idx=%0d x=%0d y=%0d n=%0d, got st=%0d idx=%0d x=%0d y=%0d n=%0d",
                  want.status, want.index, want.x, want.y, want.count,
                  got.status, got.index, got.x, got.y, got.count));
         end
      end
      rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_empty_list();
      send_request(FN_INSERT, 16'sd5, -16'sd5);
      send_request(FN_MOVE, 16'sh7FFF, 16'sh8000);
      send_request(FN_QUERY, 16'sd0, 16'sd0);
   endtask

   task automatic test_basic_ops();
      send_request(FN_START, 16'sh8000, 16'sh7FFF);
      send_request(FN_QUERY, 16'sh7FFF, 16'sh8000);
      send_request(FN_INSERT, 16'sh8000, 16'sh7FFF);
      send_request(FN_INSERT, 16'sd0, 16'sd0);
      send_request(FN_INSERT, 16'sd100, 16'sd0);
      send_request(FN_INSERT, -16'sd10, 16'sd0);
      send_request(FN_QUERY, -16'sd5, 16'sd0);
      send_request(FN_INSERT, 16'sd50, 16'sd0);
      send_request(FN_INSERT, 16'sd50, 16'sd0);
      send_request(FN_QUERY, 16'sd75, 16'sd0);
      send_request(FN_MOVE, 16'sh7FFF, 16'sh7FFF);
      send_request(FN_QUERY, 16'sd0, 16'sd0);
      send_request(FN_MOVE, 16'sh8000, 16'sh8000);
      send_request(FN_QUERY, 16'sh7FFF, 16'sh7FFF);
      send_request(FN_START, 16'sd0, 16'sd0);
      send_request(FN_INSERT, 16'sh7FFF, 16'sh7FFF);
      send_request(FN_INSERT, 16'sh8000, 16'sh8000);
      send_request(FN_QUERY, -16'sd1, -16'sd1);
      send_request(FN_MOVE, 16'sh8000, 16'sd0);
      send_request(FN_QUERY, 16'sh7FFF, 16'sh8000);
      send_request(FN_MOVE, -16'sd1, 16'sd1);
      send_request(FN_QUERY, 16'sd1, -16'sd1);
   endtask

   task automatic test_fill_to_capacity();
      send_request(FN_START, -16'sd30000, 16'sd0);
      for (int i = 1; i < MAX_PTS; i++)
         send_request(FN_INSERT, 16'(-30000 + 200 * i), 16'(i % 7));
      send_request(FN_INSERT, 16'sd25000, 16'sd5);
      send_request(FN_INSERT, -16'sd29800, 16'sd1);
      send_request(FN_QUERY, 16'sh7FFF, 16'sh7FFF);
      send_request(FN_MOVE, 16'sh7FFF, 16'sh8000);
      send_request(FN_QUERY, 16'sd0, 16'sd0);
      send_request(FN_INSERT, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_polylines(int n_items);
      int                 sent, span, op;
      logic signed [15:0] px, py;
      sent = 0;
      while (sent < n_items) begin
         pick_point(px, py);
         send_request(FN_START, px, py);
         sent++;
         span = ($urandom_range(19) == 0) ? $urandom_range(120, 350) : $urandom_range(1, 40);
         for (int k = 0; k < span && sent < n_items; k++) begin
            op = $urandom_range(99);
            pick_point(px, py);
            if (op < 65) begin
               send_request(FN_INSERT, px, py);
            end else if (op < 85) begin
               send_request(FN_QUERY, px, py);
            end else if (op < 97) begin
               if ($urandom_range(2) == 0) begin
                  px = extreme_coord();
                  py = extreme_coord();
               end
               send_request(FN_MOVE, px, py);
            end else begin
               send_request(FN_START, px, py);
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_basic_ops();
      wait_replies_drained();
      test_fill_to_capacity();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      test_random_polylines(350);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      test_random_polylines(800);
      wait_replies_drained();
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0)
         report_failure($sformatf("%0d replies never arrived", pending_replies.size()));
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
